// File: src/gqe_pkg.sv
// gqe_pkg: shared constants, codes, payload structs and controller types
// for the greedy quad extractor; no dependencies
package gqe_pkg;

    localparam int GRID      = 16;
    localparam int TYPE_BITS = 8;
    localparam int IDX_W     = $clog2(GRID);
    localparam int SIZE_W    = $clog2(GRID) + 1;
    localparam int CELL_AW   = 2 * IDX_W;
    localparam int CELLS     = GRID * GRID;
    localparam int FTYPE_W   = 8;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(GRID);

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [PADDR_W-3:0] REG_ACTIVE_SIZE = '0;

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   cell_row;
        logic [IDX_W-1:0]   cell_col;
        logic               visible;
        logic [FTYPE_W-1:0] cell_type;
    } gqe_in_t;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   quad_row;
        logic [IDX_W-1:0]   quad_col;
        logic [SIZE_W-1:0]  quad_width;
        logic [SIZE_W-1:0]  quad_height;
        logic [FTYPE_W-1:0] quad_type;
    } gqe_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_TYPE,
        S_WCHK,
        S_WCMP,
        S_HCHK,
        S_HCMP,
        S_CLEAR,
        S_OUT
    } gqe_state_t;

    typedef struct packed {
        logic load;
        logic write_cell;
        logic scan_init;
        logic scan_next;
        logic take_origin;
        logic take_type;
        logic read_wcell;
        logic w_inc;
        logic h_init;
        logic h_inc;
        logic read_hcell;
        logic i_inc;
        logic clr_init;
        logic clear_row;
        logic push;
    } gqe_cmd_t;

    typedef struct packed {
        logic is_extract;
        logic u_end;
        logic row_hit;
        logic w_ok;
        logic rd_match;
        logic row_done;
        logic h_ok;
        logic clr_last;
        logic out_busy;
    } gqe_status_t;

endpackage

// File: src/gqe_ram.sv
// gqe_ram: generic single write port, single read port ram with registered read
// no dependencies
module gqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/gqe_ctrl.sv
// gqe_ctrl: sequencer for cell writes and rectangle extraction
// depends on gqe_pkg
module gqe_ctrl
    import gqe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  gqe_status_t status,
    output gqe_cmd_t    cmd
);

    gqe_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (status.is_extract) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end else begin
                    cmd.write_cell = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN: begin
                if (status.u_end) begin
                    state_next = S_OUT;
                end else if (status.row_hit) begin
                    cmd.take_origin = 1'b1;
                    state_next      = S_TYPE;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_TYPE: begin
                cmd.take_type = 1'b1;
                state_next    = S_WCHK;
            end
            S_WCHK: begin
                if (status.w_ok) begin
                    cmd.read_wcell = 1'b1;
                    state_next     = S_WCMP;
                end else begin
                    cmd.h_init = 1'b1;
                    state_next = S_HCHK;
                end
            end
            S_WCMP: begin
                if (status.rd_match) begin
                    cmd.w_inc  = 1'b1;
                    state_next = S_WCHK;
                end else begin
                    cmd.h_init = 1'b1;
                    state_next = S_HCHK;
                end
            end
            S_HCHK: begin
                if (status.row_done) begin
                    cmd.h_inc = 1'b1;
                end else if (status.h_ok) begin
                    cmd.read_hcell = 1'b1;
                    state_next     = S_HCMP;
                end else begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end
            end
            S_HCMP: begin
                if (status.rd_match) begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_HCHK;
                end else begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end
            end
            S_CLEAR: begin
                cmd.clear_row = 1'b1;
                if (status.clr_last) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!status.out_busy) begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/gqe_dp.sv
// gqe_dp: presence bits, type ram, scan and growth counters, output register
// depends on gqe_pkg and gqe_ram
module gqe_dp
    import gqe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  gqe_cmd_t          cmd,
    output gqe_status_t       status,
    input  logic [SIZE_W-1:0] active_size,
    input  gqe_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output gqe_out_t          m_data
);

    logic [GRID-1:0]      pres_reg [GRID];
    logic [GRID-1:0]      pres_next [GRID];
    gqe_in_t              item_reg;
    logic [SIZE_W-1:0]    u_reg;
    logic [IDX_W-1:0]     v_reg;
    logic [SIZE_W-1:0]    w_reg;
    logic [SIZE_W-1:0]    h_reg;
    logic [SIZE_W-1:0]    i_reg;
    logic [TYPE_BITS-1:0] t_reg;
    logic                 found_reg;
    logic                 m_valid_reg;
    gqe_out_t             m_data_reg;

    logic [SIZE_W-1:0]    eff_size;
    logic [GRID-1:0]      col_mask;
    logic [GRID-1:0]      clr_mask;
    logic [GRID-1:0]      scan_row;
    logic [IDX_W-1:0]     low_col;
    logic [SIZE_W:0]      wrow;
    logic [SIZE_W:0]      hrow;
    logic [SIZE_W:0]      hcol;
    logic [SIZE_W:0]      hend;
    logic                 in_range;
    logic                 ram_we;
    logic                 ram_re;
    logic [CELL_AW-1:0]   ram_raddr;
    logic [TYPE_BITS-1:0] ram_rdata;
    gqe_out_t             result;

    always_comb begin
        if (active_size == '0) begin
            eff_size = SIZE_W'(1);
        end else if (active_size > SIZE_W'(GRID)) begin
            eff_size = SIZE_W'(GRID);
        end else begin
            eff_size = active_size;
        end
    end

    assign wrow = {1'b0, u_reg} + {1'b0, w_reg};
    assign hrow = {1'b0, u_reg} + {1'b0, i_reg};
    assign hcol = (SIZE_W + 1)'(v_reg) + {1'b0, h_reg};
    assign hend = (SIZE_W + 1)'(v_reg) + {1'b0, h_reg};

    always_comb begin
        for (int c = 0; c < GRID; c++) begin
            col_mask[c] = (SIZE_W'(c) < eff_size);
            clr_mask[c] = ((SIZE_W + 1)'(c) >= (SIZE_W + 1)'(v_reg)) &&
                          ((SIZE_W + 1)'(c) < hend);
        end
    end

    assign scan_row = pres_reg[u_reg[IDX_W-1:0]] & col_mask;

    always_comb begin
        low_col = '0;
        for (int c = GRID - 1; c >= 0; c--) begin
            if (scan_row[c]) begin
                low_col = IDX_W'(c);
            end
        end
    end

    assign in_range = ({1'b0, item_reg.cell_row} < eff_size) &&
                      ({1'b0, item_reg.cell_col} < eff_size);

    // status back to the sequencer
    assign status.is_extract = (item_reg.opcode == OP_EXTRACT);
    assign status.u_end      = (u_reg >= eff_size);
    assign status.row_hit    = |scan_row;
    assign status.w_ok       = (wrow < (SIZE_W + 1)'(eff_size)) &&
                               pres_reg[wrow[IDX_W-1:0]][v_reg];
    assign status.rd_match   = (ram_rdata == t_reg);
    assign status.row_done   = (i_reg == w_reg);
    assign status.h_ok       = (hcol < (SIZE_W + 1)'(eff_size)) &&
                               pres_reg[hrow[IDX_W-1:0]][hcol[IDX_W-1:0]];
    assign status.clr_last   = ((SIZE_W + 1)'(i_reg) + (SIZE_W + 1)'(1)) ==
                               (SIZE_W + 1)'(w_reg);
    assign status.out_busy   = m_valid_reg && !m_ready;

    // type ram ports
    assign ram_we = cmd.write_cell && in_range && item_reg.visible;
    assign ram_re = cmd.take_origin || cmd.read_wcell || cmd.read_hcell;

    always_comb begin
        if (cmd.take_origin) begin
            ram_raddr = {u_reg[IDX_W-1:0], low_col};
        end else if (cmd.read_wcell) begin
            ram_raddr = {wrow[IDX_W-1:0], v_reg};
        end else begin
            ram_raddr = {hrow[IDX_W-1:0], hcol[IDX_W-1:0]};
        end
    end

    gqe_ram #(
        .WIDTH (TYPE_BITS),
        .DEPTH (CELLS)
    ) u_type_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr ({item_reg.cell_row, item_reg.cell_col}),
        .wr_data (item_reg.cell_type[TYPE_BITS-1:0]),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // presence bit updates
    always_comb begin
        for (int r = 0; r < GRID; r++) begin
            pres_next[r] = pres_reg[r];
        end
        if (cmd.write_cell && in_range) begin
            pres_next[item_reg.cell_row][item_reg.cell_col] = item_reg.visible;
        end
        if (cmd.clear_row) begin
            pres_next[hrow[IDX_W-1:0]] = pres_reg[hrow[IDX_W-1:0]] & ~clr_mask;
        end
    end

    always_comb begin
        result = '0;
        if (found_reg) begin
            result.found       = 1'b1;
            result.quad_row    = u_reg[IDX_W-1:0];
            result.quad_col    = v_reg;
            result.quad_width  = w_reg;
            result.quad_height = h_reg;
            result.quad_type   = FTYPE_W'(t_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < GRID; r++) begin
                pres_reg[r] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else begin
            for (int r = 0; r < GRID; r++) begin
                pres_reg[r] <= pres_next[r];
            end
            if (cmd.push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.scan_init) begin
            u_reg     <= '0;
            found_reg <= 1'b0;
        end else if (cmd.scan_next) begin
            u_reg <= u_reg + SIZE_W'(1);
        end
        if (cmd.take_origin) begin
            v_reg     <= low_col;
            w_reg     <= SIZE_W'(1);
            found_reg <= 1'b1;
        end else if (cmd.w_inc) begin
            w_reg <= w_reg + SIZE_W'(1);
        end
        if (cmd.take_type) begin
            t_reg <= ram_rdata;
        end
        if (cmd.h_init) begin
            h_reg <= SIZE_W'(1);
        end else if (cmd.h_inc) begin
            h_reg <= h_reg + SIZE_W'(1);
        end
        if (cmd.h_init || cmd.h_inc || cmd.clr_init) begin
            i_reg <= '0;
        end else if (cmd.i_inc || cmd.clear_row) begin
            i_reg <= i_reg + SIZE_W'(1);
        end
        if (cmd.push) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: src/greedy_quad_extractor.sv
// greedy_quad_extractor: top level with configuration register and assertions
// depends on gqe_pkg, gqe_ctrl and gqe_dp
//
// Usage:
//   s_ channel takes one command per transaction: opcode write stores one cell
//   (presence bit, and type if visible), opcode extract pulls the next merged rectangle.
//   m_ channel gives one result per extract and nothing for a write.
//   The APB port holds active_size at byte address 0 (used saturated to 1..16).
// Sequencing, one command at a time (s_ready is high only while idle):
//   write: the item is registered on accept and applied in S_EXEC, then the
//     sequencer returns to idle.
//   extract: S_SCAN skips empty rows, the type of the first set cell is
//     taken and cells down its column are compared (S_WCHK, S_WCMP); each
//     further column is checked row by row (S_HCHK, S_HCMP) until one fails,
//     the covered rows are cleared (S_CLEAR) and S_OUT loads the result once
//     the output register is free. An empty slice goes from S_SCAN to S_OUT.
// Reset clears every presence bit, sets active_size to 16 and empties the
// output register; the type store is not cleared.
// A stalled receiver holds the result in the output register; the next
// command is still accepted and runs up to its own result, then waits.
module greedy_quad_extractor
    import gqe_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  gqe_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output gqe_out_t           m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SIZE_W-1:0] active_size_reg;
    logic              cfg_sel;
    gqe_cmd_t          cmd;
    gqe_status_t       status;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_ACTIVE_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_size_reg <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            active_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = cfg_sel ? PDATA_W'(active_size_reg) : '0;

    gqe_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gqe_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .active_size (active_size_reg),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // empty slice result carries no rectangle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |->
            (m_data.quad_row == '0 && m_data.quad_col == '0 &&
             m_data.quad_width == '0 && m_data.quad_height == '0 &&
             m_data.quad_type == '0))
        else $error("empty result with non-zero fields");

    // an extracted rectangle is at least one cell and stays inside the grid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.found) |->
            (m_data.quad_width != '0 && m_data.quad_height != '0 &&
             ((SIZE_W + 1)'(m_data.quad_row) + (SIZE_W + 1)'(m_data.quad_width)
                 <= (SIZE_W + 1)'(GRID)) &&
             ((SIZE_W + 1)'(m_data.quad_col) + (SIZE_W + 1)'(m_data.quad_height)
                 <= (SIZE_W + 1)'(GRID))))
        else $error("rectangle outside the grid");

    // a result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.push |-> (!m_valid || m_ready))
        else $error("result overwritten before transfer");

endmodule
